FILE: rtl/bsob_pkg.sv
// Shared types and constants for the monochrome blitter core.
// Used by the front end, the back end and the top level; depends on nothing.
package bsob_pkg;

  // Frame store geometry
  localparam int ROW_BYTES    = 16;
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 128;
  localparam int STORE_BYTES  = ROW_BYTES * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  // Signed blit address, room for walking far past either end of the store
  localparam int SADDR_W      = ADDR_W + 3;
  // Unsigned box address (row up to 381, column up to 47)
  localparam int BADDR_W      = ADDR_W + 2;
  localparam int CLR_W        = ADDR_W + 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_BLIT  = 3'd1,
    CMD_SRC   = 3'd2,
    CMD_BOX   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_BOX_SET,
    ST_RD_WAIT,
    ST_RDOUT
  } state_e;

  // One classified command word as held in the queue
  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  pos_x;
    logic [6:0]  pos_y;
    logic [7:0]  size_w;
    logic [7:0]  size_h;
    logic        rotate;
    logic [7:0]  src_byte;
    logic [10:0] rd_addr;
  } op_t;

  // Reverse the bit order of a byte
  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

FILE: rtl/bsob_if.sv
// Handshake channels of the blitter core: command words in, read data out.
// Depends on nothing.
interface bsob_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [6:0]  pos_x;
  logic [6:0]  pos_y;
  logic [7:0]  size_w;
  logic [7:0]  size_h;
  logic        rotate;
  logic [7:0]  src_byte;
  logic [10:0] rd_addr;

  modport source (output valid, cmd, pos_x, pos_y, size_w, size_h, rotate, src_byte,
                  rd_addr, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, size_w, size_h, rotate, src_byte,
                  rd_addr, output ready);
endinterface

interface bsob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rd_data;

  modport source (output valid, rd_data, input ready);
  modport sink   (input valid, rd_data, output ready);
endinterface

FILE: rtl/bsob_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bsob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read of the address being written sees old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bsob_front.sv
// Front end: accepts command words, drops unused codes, queues the rest.
// Depends on bsob_pkg and bsob_in_if.
module bsob_front
  import bsob_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bsob_in_if.sink    in_i,
  output logic       op_valid_o,
  output op_t        op_o,
  input  logic       op_pop_i
);

  op_t               entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              accept, push, known;
  op_t               word;

  assign in_i.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  // Classify: only defined commands enter the queue
  always_comb begin
    word.cmd      = cmd_e'(in_i.cmd);
    word.pos_x    = in_i.pos_x;
    word.pos_y    = in_i.pos_y;
    word.size_w   = in_i.size_w;
    word.size_h   = in_i.size_h;
    word.rotate   = in_i.rotate;
    word.src_byte = in_i.src_byte;
    word.rd_addr  = in_i.rd_addr;
    case (in_i.cmd) inside
      CMD_CLEAR, CMD_BLIT, CMD_SRC, CMD_BOX, CMD_READ: known = 1'b1;
      default:                                         known = 1'b0;
    endcase
  end

  assign push       = accept && known;
  assign op_valid_o = (count_q != '0);
  assign op_o       = entries_q[rd_ptr_q];

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= word;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (op_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push) - QCNT_W'(op_pop_i);
    end
  end

endmodule

FILE: rtl/bsob_back.sv
// Back end: executes queued commands on the frame store, blit bytes and box sides by read-modify-write.
// Depends on bsob_pkg, bsob_out_if and bsob_ram.
module bsob_back
  import bsob_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_pop_o,
  bsob_out_if.source out_o
);

  state_e state_q, state_d;

  // Blit progress
  logic signed [SADDR_W-1:0] row_start_q, row_start_d;
  logic signed [SADDR_W-1:0] write_addr_q, write_addr_d;
  logic [2:0]                bit_offset_q, bit_offset_d;
  logic [7:0]                spill_q, spill_d;
  logic [5:0]                bytes_left_q, bytes_left_d;
  logic [5:0]                row_bytes_q, row_bytes_d;
  logic [7:0]                rows_left_q, rows_left_d;
  logic                      rot_q, rot_d;

  // Pending read-modify-write
  logic signed [SADDR_W-1:0] rmw_addr_q, rmw_addr_d;
  logic [7:0]                rmw_val_q, rmw_val_d;
  logic                      spill_pend_q, spill_pend_d;
  logic signed [SADDR_W-1:0] spill_addr_q, spill_addr_d;
  logic [7:0]                spill_val_q, spill_val_d;

  // Box walk
  logic [5:0]  box_c_q, box_c_d;
  logic [3:0]  box_lc_q, box_lc_d;
  logic [5:0]  box_rc_q, box_rc_d;
  logic [7:0]  box_lm_q, box_lm_d;
  logic [7:0]  box_rm_q, box_rm_d;
  logic [8:0]  box_y_q, box_y_d;
  logic [8:0]  box_yb_q, box_yb_d;
  logic [8:0]  box_r_q, box_r_d;
  logic [2:0]  box_xl_q, box_xl_d;
  logic [2:0]  box_xr_q, box_xr_d;
  logic        box_phase_q, box_phase_d;
  logic        side_q, side_d;

  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_data_q, out_data_d;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr_q, ram_raddr_d;
  logic [7:0]        ram_wdata, ram_rdata;

  // Combinational helpers
  logic                      rmw_in_range;
  logic signed [SADDR_W-1:0] rot_col, rot_t, row_s, start_addr, wa_next, rs_next;
  logic [15:0]               sh_up, sh_rot;
  logic [7:0]                byte_val, spill_next, box_mask;
  logic [8:0]                xe, r_next;
  logic [5:0]                rbc;
  logic [BADDR_W-1:0]        box_addr;

  bsob_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr_q),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.rd_data = out_data_q;

  assign rmw_in_range = !rmw_addr_q[SADDR_W-1] &&
                        (rmw_addr_q[SADDR_W-2:0] < (SADDR_W-1)'(STORE_BYTES));

  // Next state and datapath
  always_comb begin
    state_d      = state_q;
    row_start_d  = row_start_q;
    write_addr_d = write_addr_q;
    bit_offset_d = bit_offset_q;
    spill_d      = spill_q;
    bytes_left_d = bytes_left_q;
    row_bytes_d  = row_bytes_q;
    rows_left_d  = rows_left_q;
    rot_d        = rot_q;
    rmw_addr_d   = rmw_addr_q;
    rmw_val_d    = rmw_val_q;
    spill_pend_d = spill_pend_q;
    spill_addr_d = spill_addr_q;
    spill_val_d  = spill_val_q;
    box_c_d      = box_c_q;
    box_lc_d     = box_lc_q;
    box_rc_d     = box_rc_q;
    box_lm_d     = box_lm_q;
    box_rm_d     = box_rm_q;
    box_y_d      = box_y_q;
    box_yb_d     = box_yb_q;
    box_r_d      = box_r_q;
    box_xl_d     = box_xl_q;
    box_xr_d     = box_xr_q;
    box_phase_d  = box_phase_q;
    side_d       = side_q;
    clr_cnt_d    = clr_cnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_data_d   = out_data_q;
    ram_raddr_d  = ram_raddr_q;
    ram_we       = 1'b0;
    ram_waddr    = rmw_addr_q[ADDR_W-1:0];
    ram_wdata    = ram_rdata | rmw_val_q;
    op_pop_o     = 1'b0;

    // Blit start geometry
    rbc     = 6'((9'(op_i.size_w) + 9'd7) >> 3);
    rot_t   = SADDR_W'(FRAME_WIDTH - 1) - SADDR_W'(op_i.pos_x);
    rot_col = rot_t >>> 3;
    row_s   = SADDR_W'(FRAME_HEIGHT - 1) - SADDR_W'(op_i.pos_y);
    if (op_i.rotate) begin
      start_addr = SADDR_W'(row_s * SADDR_W'(ROW_BYTES)) + rot_col;
    end else begin
      start_addr = SADDR_W'(SADDR_W'(op_i.pos_y) * SADDR_W'(ROW_BYTES)) +
                   SADDR_W'(op_i.pos_x[6:3]);
    end

    // Shifted source byte and its spill
    sh_up  = {8'd0, op_i.src_byte} << bit_offset_q;
    sh_rot = {flip8(op_i.src_byte), 8'd0} >> bit_offset_q;
    if (rot_q) begin
      byte_val   = spill_q | (flip8(op_i.src_byte) >> bit_offset_q);
      spill_next = sh_rot[7:0];
      wa_next    = write_addr_q - SADDR_W'(1);
      rs_next    = row_start_q - SADDR_W'(ROW_BYTES);
    end else begin
      byte_val   = spill_q | sh_up[7:0];
      spill_next = sh_up[15:8];
      wa_next    = write_addr_q + SADDR_W'(1);
      rs_next    = row_start_q + SADDR_W'(ROW_BYTES);
    end

    xe = 9'(op_i.pos_x) + 9'(op_i.size_w) - 9'd1;

    // Edge mask of the current box column
    box_mask = 8'hFF;
    if (box_c_q == 6'(box_lc_q)) box_mask = box_mask & box_lm_q;
    if (box_c_q == box_rc_q)     box_mask = box_mask & box_rm_q;
    box_addr = BADDR_W'((box_phase_q ? box_yb_q : box_y_q)) * BADDR_W'(ROW_BYTES) +
               BADDR_W'(box_c_q);
    r_next   = box_r_q + 9'd1;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q[ADDR_W-1:0];
        ram_wdata = 8'd0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_W'(STORE_BYTES - 1)) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (op_valid_i) begin
          case (op_i.cmd)
            CMD_CLEAR: begin
              op_pop_o  = 1'b1;
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
            CMD_BLIT: begin
              op_pop_o     = 1'b1;
              rot_d        = op_i.rotate;
              spill_d      = 8'd0;
              row_bytes_d  = rbc;
              bytes_left_d = rbc;
              rows_left_d  = (rbc == '0) ? 8'd0 : op_i.size_h;
              bit_offset_d = op_i.rotate ? 3'd7 - rot_t[2:0] : op_i.pos_x[2:0];
              row_start_d  = start_addr;
              write_addr_d = start_addr;
            end
            CMD_SRC: begin
              op_pop_o = 1'b1;
              if (rows_left_q != '0) begin
                rmw_addr_d   = write_addr_q;
                rmw_val_d    = byte_val;
                spill_d      = spill_next;
                write_addr_d = wa_next;
                bytes_left_d = bytes_left_q - 1'b1;
                state_d      = ST_RD;
                ram_raddr_d  = write_addr_q[ADDR_W-1:0];
                if (bytes_left_q == 6'd1) begin
                  // Row ends: flush the spill past the last byte, then step row
                  spill_pend_d = (bit_offset_q != 3'd0);
                  spill_addr_d = wa_next;
                  spill_val_d  = spill_next;
                  row_start_d  = rs_next;
                  write_addr_d = rs_next;
                  spill_d      = 8'd0;
                  bytes_left_d = row_bytes_q;
                  rows_left_d  = rows_left_q - 1'b1;
                end
              end
            end
            CMD_BOX: begin
              op_pop_o = 1'b1;
              if (op_i.size_w != '0 && op_i.size_h != '0) begin
                box_c_d     = 6'(op_i.pos_x[6:3]);
                box_lc_d    = op_i.pos_x[6:3];
                box_rc_d    = 6'(xe[8:3]);
                box_lm_d    = 8'hFF << op_i.pos_x[2:0];
                box_rm_d    = 8'hFF >> (3'd7 - xe[2:0]);
                box_y_d     = 9'(op_i.pos_y);
                box_yb_d    = 9'(op_i.pos_y) + 9'(op_i.size_h) - 9'd1;
                box_xl_d    = op_i.pos_x[2:0];
                box_xr_d    = xe[2:0];
                box_phase_d = 1'b0;
                state_d     = ST_BOX_SET;
              end
            end
            CMD_READ: begin
              if (!out_valid_q || out_o.ready) begin
                op_pop_o    = 1'b1;
                ram_raddr_d = op_i.rd_addr;
                state_d     = ST_RD_WAIT;
              end
            end
            default: begin
              op_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_RD: begin
        state_d = ST_WR;
      end

      ST_WR: begin
        ram_we    = rmw_in_range;
        ram_waddr = rmw_addr_q[ADDR_W-1:0];
        ram_wdata = ram_rdata | rmw_val_q;
        state_d   = ST_IDLE;
        if (spill_pend_q) begin
          spill_pend_d = 1'b0;
          rmw_addr_d   = spill_addr_q;
          rmw_val_d    = spill_val_q;
          ram_raddr_d  = spill_addr_q[ADDR_W-1:0];
          state_d      = ST_RD;
        end else if (side_q) begin
          if (!box_phase_q) begin
            box_phase_d = 1'b1;
            rmw_addr_d  = SADDR_W'(BADDR_W'(box_r_q) * BADDR_W'(ROW_BYTES) +
                                   BADDR_W'(box_rc_q));
            rmw_val_d   = 8'd1 << box_xr_q;
            ram_raddr_d = ADDR_W'(BADDR_W'(box_r_q) * BADDR_W'(ROW_BYTES) +
                                  BADDR_W'(box_rc_q));
            state_d     = ST_RD;
          end else begin
            box_phase_d = 1'b0;
            box_r_d     = r_next;
            if (r_next < box_yb_q) begin
              rmw_addr_d  = SADDR_W'(BADDR_W'(r_next) * BADDR_W'(ROW_BYTES) +
                                     BADDR_W'(box_lc_q));
              rmw_val_d   = 8'd1 << box_xl_q;
              ram_raddr_d = ADDR_W'(BADDR_W'(r_next) * BADDR_W'(ROW_BYTES) +
                                    BADDR_W'(box_lc_q));
              state_d     = ST_RD;
            end else begin
              side_d = 1'b0;
            end
          end
        end
      end

      ST_BOX_SET: begin
        // Overwrite top and bottom rows, one byte a cycle
        ram_we      = (box_addr < BADDR_W'(STORE_BYTES));
        ram_waddr   = box_addr[ADDR_W-1:0];
        ram_wdata   = box_mask;
        box_phase_d = !box_phase_q;
        if (box_phase_q) begin
          box_c_d = box_c_q + 1'b1;
          if (box_c_q == box_rc_q) begin
            box_r_d = box_y_q + 9'd1;
            if (box_y_q + 9'd1 < box_yb_q) begin
              side_d      = 1'b1;
              rmw_addr_d  = SADDR_W'(BADDR_W'(box_y_q + 9'd1) * BADDR_W'(ROW_BYTES) +
                                     BADDR_W'(box_lc_q));
              rmw_val_d   = 8'd1 << box_xl_q;
              ram_raddr_d = ADDR_W'(BADDR_W'(box_y_q + 9'd1) * BADDR_W'(ROW_BYTES) +
                                    BADDR_W'(box_lc_q));
              state_d     = ST_RD;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      // Wait for the registered RAM read of the requested byte
      ST_RD_WAIT: begin
        state_d = ST_RDOUT;
      end

      ST_RDOUT: begin
        out_valid_d = 1'b1;
        out_data_d  = ram_rdata;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      row_start_q  <= '0;
      write_addr_q <= '0;
      bit_offset_q <= '0;
      spill_q      <= '0;
      bytes_left_q <= '0;
      row_bytes_q  <= '0;
      rows_left_q  <= '0;
      rot_q        <= 1'b0;
      spill_pend_q <= 1'b0;
      side_q       <= 1'b0;
      box_phase_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      out_valid_q  <= out_valid_d;
      row_start_q  <= row_start_d;
      write_addr_q <= write_addr_d;
      bit_offset_q <= bit_offset_d;
      spill_q      <= spill_d;
      bytes_left_q <= bytes_left_d;
      row_bytes_q  <= row_bytes_d;
      rows_left_q  <= rows_left_d;
      rot_q        <= rot_d;
      spill_pend_q <= spill_pend_d;
      side_q       <= side_d;
      box_phase_q  <= box_phase_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rmw_addr_q   <= rmw_addr_d;
    rmw_val_q    <= rmw_val_d;
    spill_addr_q <= spill_addr_d;
    spill_val_q  <= spill_val_d;
    box_c_q      <= box_c_d;
    box_lc_q     <= box_lc_d;
    box_rc_q     <= box_rc_d;
    box_lm_q     <= box_lm_d;
    box_rm_q     <= box_rm_d;
    box_y_q      <= box_y_d;
    box_yb_q     <= box_yb_d;
    box_r_q      <= box_r_d;
    box_xl_q     <= box_xl_d;
    box_xr_q     <= box_xr_d;
    out_data_q   <= out_data_d;
    ram_raddr_q  <= ram_raddr_d;
  end

endmodule

FILE: rtl/bit_shift_or_blitter_core.sv
// Top level of the monochrome blitter: command front end, queue and store back end.
// Depends on bsob_pkg, bsob_if, bsob_front, bsob_back and bsob_ram.
//
//   port    | dir | words
//   --------+-----+-----------------------------------------------
//   in_i    | in  | commands: clear, blit start, source byte, box, read
//   out_o   | out | rd_data, one word for each read command
//
// Source byte: one RAM read-modify-write (RMW), plus a second one for the spill when
// a row ends with a nonzero bit shift. Read: RAM read, then output word.
// Box: top/bottom bytes overwritten, side bits by RMW. Clear: zeroes all 2048 bytes,
// and reset runs the same clearing pass first. A two-word queue lets input words land
// while the back end works or the output word waits.
module bit_shift_or_blitter_core
  import bsob_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bsob_in_if.sink    in_i,
  bsob_out_if.source out_o
);

  logic op_valid, op_pop;
  op_t  op;

  bsob_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  bsob_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .out_o      (out_o)
  );

endmodule
